@@ hdl/tdpt_pkg.sv @@
// tdpt_pkg: shared types and constants for the trial division prime test
// holds micro-operation codes, jump conditions, the control word and the status bundle
// no dependencies
`timescale 1ns / 1ps

package tdpt_pkg;

    // width of the step counter
    localparam int STEP_BITS = 4;

    // step addresses of the microprogram
    localparam logic [STEP_BITS-1:0] STEP_WAIT      = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_INIT      = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_CHECK     = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_DIV_START = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_DIV_STEP  = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_NEXT_D    = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_LOOP      = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_COMPOSITE = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_PUBLISH   = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_RETURN    = 4'd9;

    // datapath micro-operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_NEXT_D,
        OP_CLR_PRIME,
        OP_PUBLISH
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_TAKE,
        C_LT2,
        C_SQ_GT_N,
        C_DIV_MORE,
        C_REM_ZERO,
        C_OUT_BUSY
    } cond_t;

    // one control word of the microprogram
    typedef struct packed {
        op_t                  op;
        cond_t                cond;
        logic [STEP_BITS-1:0] target;
    } ctrl_word_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic in_take;
        logic lt2;
        logic sq_gt_n;
        logic div_more;
        logic rem_zero;
        logic out_busy;
    } status_t;

endpackage

@@ hdl/trial_division_prime_test.sv @@
// trial_division_prime_test: top level of the trial division primality tester
// instantiates tdpt_sequencer and tdpt_datapath; depends on tdpt_pkg
`timescale 1ns / 1ps

// Tests one candidate at a time for primality by trial division and returns the
// candidate, a prime flag and a report flag (prime and below upper_bound). Zero and
// one are not prime. A candidate is taken only while the sequencer waits at its first
// step; a finished result sits in an output register, so the next candidate can be
// taken while it waits. A candidate below two skips the divisor loop. Any other
// candidate is divided by each divisor in turn, from 2 up to the smallest factor, or up
// to the integer square root for a prime. Each divisor costs one bit-serial remainder
// pass over the VALUE_BITS candidate bits plus four control steps of the microprogram.
// While an earlier result is still stalled in the output register the sequencer waits
// at its publish step until the register is free.
module trial_division_prime_test
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] candidate,
    input  logic [VALUE_BITS-1:0] upper_bound,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] tested_value,
    output logic                  prime_flag,
    output logic                  report
);
    import tdpt_pkg::*;

    op_t     op;
    status_t status;
    logic    in_take;

    // input transaction accepted this cycle
    assign in_take = in_valid && !in_stall;

    // microprogram control
    tdpt_sequencer u_sequencer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .op       (op),
        .in_stall (in_stall)
    );

    // arithmetic and result register
    tdpt_datapath
    #(
        .VALUE_BITS (VALUE_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .in_take      (in_take),
        .candidate    (candidate),
        .upper_bound  (upper_bound),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tested_value (tested_value),
        .prime_flag   (prime_flag),
        .report       (report)
    );

endmodule

@@ hdl/tdpt_sequencer.sv @@
// tdpt_sequencer: step counter and microprogram rom with conditional jumps
// depends on tdpt_pkg
`timescale 1ns / 1ps

module tdpt_sequencer
(
    input  logic              clk,
    input  logic              rst_n,
    input  tdpt_pkg::status_t status,
    output tdpt_pkg::op_t     op,
    output logic              in_stall
);
    import tdpt_pkg::*;

    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    ctrl_word_t           word;
    logic                 jump;

    // microprogram rom: perform op, then jump to target if cond holds, else fall through
    function automatic ctrl_word_t rom(input logic [STEP_BITS-1:0] addr);
        ctrl_word_t w;
        unique case (addr)
            STEP_WAIT:      w = '{OP_NONE,      C_NO_TAKE,  STEP_WAIT};
            STEP_INIT:      w = '{OP_INIT,      C_LT2,      STEP_COMPOSITE};
            STEP_CHECK:     w = '{OP_NONE,      C_SQ_GT_N,  STEP_PUBLISH};
            STEP_DIV_START: w = '{OP_DIV_START, C_NEVER,    STEP_WAIT};
            STEP_DIV_STEP:  w = '{OP_DIV_STEP,  C_DIV_MORE, STEP_DIV_STEP};
            STEP_NEXT_D:    w = '{OP_NEXT_D,    C_REM_ZERO, STEP_COMPOSITE};
            STEP_LOOP:      w = '{OP_NONE,      C_ALWAYS,   STEP_CHECK};
            STEP_COMPOSITE: w = '{OP_CLR_PRIME, C_NEVER,    STEP_WAIT};
            STEP_PUBLISH:   w = '{OP_PUBLISH,   C_OUT_BUSY, STEP_PUBLISH};
            STEP_RETURN:    w = '{OP_NONE,      C_ALWAYS,   STEP_WAIT};
            default:        w = '{OP_NONE,      C_ALWAYS,   STEP_WAIT};
        endcase
        return w;
    endfunction

    assign word = rom(step_reg);
    assign op   = word.op;

    // new transactions are taken only while waiting at the first step
    assign in_stall = (step_reg != STEP_WAIT);

    // jump condition decode
    always_comb
    begin
        unique case (word.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_TAKE:  jump = !status.in_take;
            C_LT2:      jump = status.lt2;
            C_SQ_GT_N:  jump = status.sq_gt_n;
            C_DIV_MORE: jump = status.div_more;
            C_REM_ZERO: jump = status.rem_zero;
            C_OUT_BUSY: jump = status.out_busy;
            default:    jump = 1'b0;
        endcase
        step_next = jump ? word.target : step_reg + STEP_BITS'(1);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_WAIT;
        else
            step_reg <= step_next;
    end

endmodule

@@ hdl/tdpt_datapath.sv @@
// tdpt_datapath: operand registers, bit-serial remainder unit, divisor square tracker
// and the output register; driven by micro-operations from the sequencer
// depends on tdpt_pkg
`timescale 1ns / 1ps

module tdpt_datapath
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdpt_pkg::op_t         op,
    input  logic                  in_take,
    input  logic [VALUE_BITS-1:0] candidate,
    input  logic [VALUE_BITS-1:0] upper_bound,
    output tdpt_pkg::status_t     status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] tested_value,
    output logic                  prime_flag,
    output logic                  report
);
    import tdpt_pkg::*;

    localparam int IDX_BITS = $clog2(VALUE_BITS);
    localparam int SQ_BITS  = 2 * VALUE_BITS;

    logic [VALUE_BITS-1:0] cand_reg;
    logic [VALUE_BITS-1:0] bound_reg;
    logic [VALUE_BITS-1:0] div_reg;
    logic [SQ_BITS-1:0]    sq_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [IDX_BITS-1:0]   bit_reg;
    logic                  prime_reg;

    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] tested_value_reg;
    logic                  prime_flag_reg;
    logic                  report_reg;

    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   diff;
    logic                  out_busy;
    logic                  publish;

    // one restoring step: bring down the next candidate bit and subtract if it fits
    assign shifted = {rem_reg, cand_reg[bit_reg]};
    assign diff    = shifted - {1'b0, div_reg};

    assign out_busy = out_valid_reg && out_stall;
    assign publish  = (op == OP_PUBLISH) && !out_busy;

    // flags for the sequencer
    assign status.in_take  = in_take;
    assign status.lt2      = (cand_reg[VALUE_BITS-1:1] == '0);
    assign status.sq_gt_n  = (sq_reg > {{VALUE_BITS{1'b0}}, cand_reg});
    assign status.div_more = (bit_reg != '0);
    assign status.rem_zero = (rem_reg == '0);
    assign status.out_busy = out_busy;

    // operand and working registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cand_reg  <= candidate;
            bound_reg <= upper_bound;
        end
        case (op)
            OP_INIT:
            begin
                div_reg   <= VALUE_BITS'(2);
                sq_reg    <= SQ_BITS'(4);
                prime_reg <= 1'b1;
            end
            OP_DIV_START:
            begin
                rem_reg <= '0;
                bit_reg <= IDX_BITS'(VALUE_BITS - 1);
            end
            OP_DIV_STEP:
            begin
                rem_reg <= diff[VALUE_BITS] ? shifted[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
                bit_reg <= bit_reg - IDX_BITS'(1);
            end
            OP_NEXT_D:
            begin
                // (d+1)^2 = d^2 + 2d + 1
                div_reg <= div_reg + VALUE_BITS'(1);
                sq_reg  <= sq_reg + {{(VALUE_BITS-1){1'b0}}, div_reg, 1'b0} + SQ_BITS'(1);
            end
            OP_CLR_PRIME:
                prime_reg <= 1'b0;
            default:
            begin
            end
        endcase
    end

    // output register: holds a finished transaction until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (publish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (publish)
        begin
            tested_value_reg <= cand_reg;
            prime_flag_reg   <= prime_reg;
            report_reg       <= prime_reg && (cand_reg < bound_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign tested_value = tested_value_reg;
    assign prime_flag   = prime_flag_reg;
    assign report       = report_reg;

endmodule

@@ test/tb_trial_division_prime_test.sv @@
// tb_trial_division_prime_test: self-checking testbench for the trial division prime tester
// drives candidate transactions, predicts each verdict and checks the result stream
// depends on trial_division_prime_test and the blocks it instantiates
`timescale 1ns / 1ps

module tb_trial_division_prime_test;

    localparam int VALUE_BITS   = 31;
    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 80;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 20000000;
    localparam int IDLE_PERCENT = 23;
    localparam int MAX_REPORTED = 10;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [VALUE_BITS-1:0] candidate;
    logic [VALUE_BITS-1:0] upper_bound;
    logic                  out_valid;
    logic                  out_stall;
    logic [VALUE_BITS-1:0] tested_value;
    logic                  prime_flag;
    logic                  report;

    int cycle_count;
    bit quiet_phase;

    // expected verdicts and the checks against the result stream
    class prime_scoreboard;
        typedef struct {
            bit [VALUE_BITS-1:0] value;
            bit                  prime;
            bit                  in_range;
        } verdict_t;

        verdict_t            verdicts[$];
        bit [VALUE_BITS-1:0] held_candidate;
        bit [VALUE_BITS-1:0] trial_divisor;
        bit [VALUE_BITS-1:0] partial_remainder;
        int                  mismatches;
        int                  tested;
        int                  primes_seen;
        int                  reports_seen;

        function new();
            held_candidate    = '0;
            trial_divisor     = '0;
            partial_remainder = '0;
            mismatches        = 0;
            tested            = 0;
            primes_seen       = 0;
            reports_seen      = 0;
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("mismatch at cycle %0d: %s", cycle_count, what);
        endfunction

        // trial division up to the integer square root, first zero remainder ends it
        function void note_candidate(bit [VALUE_BITS-1:0] cand, bit [VALUE_BITS-1:0] bound);
            verdict_t        v;
            longint unsigned n;
            longint unsigned d;
            longint unsigned r;
            n                 = 64'(cand);
            r                 = 0;
            held_candidate    = cand;
            trial_divisor     = '0;
            partial_remainder = '0;
            v.value           = cand;
            v.prime           = 1'b0;
            if (n >= 2) begin
                v.prime = 1'b1;
                for (d = 2; d * d <= n; d++) begin
                    r = n % d;
                    if (r == 0) begin
                        trial_divisor = d[VALUE_BITS-1:0];
                        v.prime       = 1'b0;
                        break;
                    end
                end
                if (v.prime)
                    partial_remainder = r[VALUE_BITS-1:0];
            end
            v.in_range = v.prime && (cand < bound);
            verdicts.push_back(v);
        endfunction

        function void check_result(bit [VALUE_BITS-1:0] value, bit pflag, bit rep);
            verdict_t v;
            if (verdicts.size() == 0) begin
                flag_mismatch($sformatf("unexpected result value=%0d prime=%0b report=%0b",
                                        value, pflag, rep));
                return;
            end
            v = verdicts.pop_front();
            tested++;
            if (v.prime)
                primes_seen++;
            if (v.in_range)
                reports_seen++;
            if (value !== v.value)
                flag_mismatch($sformatf("tested_value expected %0d actual %0d", v.value, value));
            if (pflag !== v.prime)
                flag_mismatch($sformatf("prime_flag for %0d expected %0b actual %0b",
                                        v.value, v.prime, pflag));
            if (rep !== v.in_range)
                flag_mismatch($sformatf("report for %0d expected %0b actual %0b",
                                        v.value, v.in_range, rep));
        endfunction
    endclass

    prime_scoreboard board;

    trial_division_prime_test #(
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .candidate    (candidate),
        .upper_bound  (upper_bound),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tested_value (tested_value),
        .prime_flag   (prime_flag),
        .report       (report)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // cycle counter and watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d verdicts outstanding",
                 cycle_count, board.verdicts.size());
        $display("[trial_division_prime_test] ERROR");
        $finish;
    end

    // result side: check accepted transactions, stall at random outside the quiet stretch
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(tested_value, prime_flag, report);
            out_stall <= !quiet_phase && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // offer one candidate transaction, with a random gap first, and hold it until taken
    task automatic send_candidate(logic [VALUE_BITS-1:0] cand, logic [VALUE_BITS-1:0] bound);
        while (!quiet_phase && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        candidate   <= cand;
        upper_bound <= bound;
        do
            @(posedge clk);
        while (in_stall);
        board.note_candidate(cand, bound);
    endtask

    // composite with a factor of at most 300, so the search ends quickly
    function automatic logic [VALUE_BITS-1:0] cheap_composite();
        int unsigned p;
        int unsigned q;
        p = $urandom_range(2, 300);
        q = $urandom_range(2, int'(VALUE_MAX) / p);
        return VALUE_BITS'(p * q);
    endfunction

    // stimulus and end of run
    initial
    begin
        int                    sent;
        int                    sweep_left;
        int unsigned           roll;
        logic [VALUE_BITS-1:0] sweep_next;
        logic [VALUE_BITS-1:0] sweep_bound;

        board       = new();
        quiet_phase = 1'b0;
        sweep_left  = 0;
        sweep_next  = '0;
        sweep_bound = '0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        candidate   <= '0;
        upper_bound <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero and one, two and three, small composites and prime squares
        send_candidate(31'd0, VALUE_MAX);
        send_candidate(31'd1, VALUE_MAX);
        send_candidate(31'd2, 31'd3);
        send_candidate(31'd2, 31'd2);
        send_candidate(31'd3, VALUE_MAX);
        send_candidate(31'd4, VALUE_MAX);
        send_candidate(31'd9, VALUE_MAX);
        send_candidate(31'd25, 31'd100);
        send_candidate(31'd49, 31'd100);
        // bound just above, equal to and below a prime
        send_candidate(31'd97, 31'd98);
        send_candidate(31'd97, 31'd97);
        send_candidate(31'd97, 31'd0);
        send_candidate(31'd65521, VALUE_MAX);
        send_candidate(31'd1000003, 31'd1000004);
        send_candidate(31'd1018081, VALUE_MAX);
        // large candidates, all composite with small factors
        send_candidate(VALUE_MAX - 31'd1, VALUE_MAX);
        send_candidate(VALUE_MAX - 31'd2, 31'd0);
        send_candidate(31'h40000000, VALUE_MAX);
        send_candidate(31'h55555555, 31'h2AAAAAAA);
        send_candidate(31'h2AAAAAAA, 31'h55555555);

        // random part: mostly interval sweeps, the rest scattered candidates
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet_phase = (sent >= 40) && (sent < 65);
            if (sweep_left > 0) begin
                send_candidate(sweep_next, sweep_bound);
                sweep_next = sweep_next + VALUE_BITS'(1);
                sweep_left--;
            end
            else begin
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    sweep_next  = VALUE_BITS'($urandom_range(0, 3000));
                    sweep_left  = $urandom_range(4, 10);
                    sweep_bound = sweep_next
                                  + VALUE_BITS'($urandom_range(0, sweep_left + 2));
                    continue;
                end
                else if (roll < 70)
                    send_candidate(VALUE_BITS'($urandom_range(0, 1 << 18)),
                                   VALUE_BITS'($urandom()));
                else if (roll < 85)
                    send_candidate(cheap_composite(), VALUE_BITS'($urandom()));
                else
                    send_candidate(VALUE_BITS'($urandom()) & ~VALUE_BITS'(1),
                                   VALUE_BITS'($urandom()));
            end
            sent++;
        end
        quiet_phase = 1'b0;
        in_valid <= 1'b0;

        // wait for the outstanding verdicts, then watch for stray results
        while (board.verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tested %0d candidates (%0d prime, %0d reported) in %0d cycles",
                 board.tested, board.primes_seen, board.reports_seen, cycle_count);
        $display("sweeps, prime squares, bound edges and large composites, %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0 && board.verdicts.size() == 0)
            $display("[trial_division_prime_test] OK");
        else
            $display("[trial_division_prime_test] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hdl/tdpt_pkg.sv
hdl/tdpt_sequencer.sv
hdl/tdpt_datapath.sv
hdl/trial_division_prime_test.sv
test/tb_trial_division_prime_test.sv
